// File: rtl/core/gmhp_pkg.sv
`timescale 1ns / 1ps

package gmhp_pkg;

   localparam int ByteWidth  = 8;
   localparam int TimeWidth  = 32;
   localparam int XlenWidth  = 16;
   localparam int KindWidth  = 3;
   localparam int RspDataWidth = 2 * ByteWidth + TimeWidth;

   localparam logic [ByteWidth-1:0] MAGIC1_BYTE = 8'h1f;
   localparam logic [ByteWidth-1:0] MAGIC2_BYTE = 8'h8b;
   localparam logic [ByteWidth-1:0] METHOD_DEFLATE = 8'h08;

   localparam logic [ByteWidth-1:0] FL_HCRC    = 8'h02;
   localparam logic [ByteWidth-1:0] FL_EXTRA   = 8'h04;
   localparam logic [ByteWidth-1:0] FL_NAME    = 8'h08;
   localparam logic [ByteWidth-1:0] FL_COMMENT = 8'h10;

   typedef enum logic [3:0] {
      PH_MAGIC1   = 4'd0,
      PH_MAGIC2   = 4'd1,
      PH_METHOD   = 4'd2,
      PH_FLAGS    = 4'd3,
      PH_MTIME    = 4'd4,
      PH_XFL      = 4'd5,
      PH_OS       = 4'd6,
      PH_XLEN     = 4'd7,
      PH_EXTRA    = 4'd8,
      PH_NAME     = 4'd9,
      PH_COMMENT  = 4'd10,
      PH_HCRC     = 4'd11,
      PH_PAYLOAD  = 4'd12,
      PH_BADMAGIC = 4'd13,
      PH_BADMETH  = 4'd14
   } phase_type;

   typedef enum logic [KindWidth-1:0] {
      KIND_HDR      = 3'd0,
      KIND_NAME     = 3'd1,
      KIND_DONE     = 3'd2,
      KIND_BADMAGIC = 3'd3,
      KIND_BADMETH  = 3'd4,
      KIND_PAYLOAD  = 3'd5
   } kind_type;

   typedef struct packed {
      phase_type              phase;
      logic [ByteWidth-1:0]   flags;
      logic [TimeWidth-1:0]   mtime;
      logic [1:0]             byte_count;
      logic [XlenWidth-1:0]   extra_left;
   } state_type;

   localparam state_type STATE_RESET = '{
      phase:      PH_MAGIC1,
      flags:      '0,
      mtime:      '0,
      byte_count: '0,
      extra_left: '0
   };

   // First enabled optional section strictly after the one just done.
   function automatic phase_type section_after(input phase_type done,
                                               input logic [ByteWidth-1:0] flags);
      phase_type nxt;
      nxt = PH_PAYLOAD;
      if (done < PH_HCRC && (flags & FL_HCRC) != '0) nxt = PH_HCRC;
      if (done < PH_COMMENT && (flags & FL_COMMENT) != '0) nxt = PH_COMMENT;
      if (done < PH_NAME && (flags & FL_NAME) != '0) nxt = PH_NAME;
      if (done < PH_XLEN && (flags & FL_EXTRA) != '0) nxt = PH_XLEN;
      return nxt;
   endfunction

endpackage

// File: rtl/core/gzip_member_header_parser.sv
`timescale 1ns / 1ps

// Channel   Direction  Ports                       Contents
// req       in         req_tvalid/tready/tdata/tuser  one stream byte, restart flag
// rsp       out        rsp_tvalid/tready/tdata/tuser  kind, data, flags, mtime
//
// One word in, one word out. A word accepted at a clock edge has its result
// registered at that same edge, where the consumer can take it;
// a new word is taken every cycle while no stalled result waits.
// The single result register sets the rate: req_tready is low only while
// a result waits and the consumer stalls it.
// Reset (synchronous, active high) drops any pending result and returns
// the parser to expecting the first magic byte; a word with restart set
// is parsed as that first byte, and a pending result is kept.
module gzip_member_header_parser
   import gmhp_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_tvalid,
   output logic                     req_tready,
   input  logic [ByteWidth-1:0]     req_tdata,   // [7:0] in_byte
   input  logic [0:0]               req_tuser,   // [0] restart
   output logic                     rsp_tvalid,
   input  logic                     rsp_tready,
   output logic [RspDataWidth-1:0]  rsp_tdata,   // [7:0] data_out, [15:8] flags_out,
                                                 // [47:16] mtime_out
   output logic [KindWidth-1:0]     rsp_tuser    // [2:0] kind
);

   state_type            state_ff, state_in;
   kind_type             kind_in;
   logic [ByteWidth-1:0] data_in;

   logic                    rsp_valid_ff, rsp_valid_in;
   kind_type                rsp_kind_ff, rsp_kind_in;
   logic [RspDataWidth-1:0] rsp_data_ff, rsp_data_in;

   logic req_accept;

   // Take a word whenever the result slot is empty or being drained.
   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign req_accept = req_tvalid && req_tready;

   gmhp_step u_step (
      .state_cur (state_ff),
      .in_byte   (req_tdata),
      .restart   (req_tuser[0]),
      .state_nxt (state_in),
      .kind      (kind_in),
      .data_out  (data_in)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_kind_in  = rsp_kind_ff;
      rsp_data_in  = rsp_data_ff;
      if (rsp_valid_ff && rsp_tready) rsp_valid_in = 1'b0;
      if (req_accept) begin
         rsp_valid_in = 1'b1;
         rsp_kind_in  = kind_in;
         // flags and mtime show the state after this word
         rsp_data_in  = {state_in.mtime, state_in.flags, data_in};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= STATE_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (req_accept) state_ff <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers: no reset needed.
   always_ff @(posedge clock) begin
      rsp_kind_ff <= rsp_kind_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_kind_ff;
   assign rsp_tdata  = rsp_data_ff;

   // An accepted word always leaves a result behind it.
   assert property (@(posedge clock) disable iff (reset)
      req_accept |=> rsp_valid_ff)
      else $error("accepted word produced no result");

   // A stalled result blocks the input side.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_tready) |-> !req_tready)
      else $error("input accepted over a stalled result");

   // Once in payload, bytes stay payload until restart.
   assert property (@(posedge clock) disable iff (reset)
      (req_accept && !req_tuser[0] && state_ff.phase == PH_PAYLOAD)
         |=> (rsp_kind_ff == KIND_PAYLOAD))
      else $error("payload phase left without restart");

   // Bad magic is sticky until restart.
   assert property (@(posedge clock) disable iff (reset)
      (req_accept && !req_tuser[0] && state_ff.phase == PH_BADMAGIC)
         |=> (rsp_kind_ff == KIND_BADMAGIC && rsp_data_ff[ByteWidth-1:0] == '0))
      else $error("bad magic error not held");

endmodule

// File: rtl/core/gmhp_step.sv
`timescale 1ns / 1ps

module gmhp_step
   import gmhp_pkg::*;
(
   input  state_type            state_cur,
   input  logic [ByteWidth-1:0] in_byte,
   input  logic                 restart,
   output state_type            state_nxt,
   output kind_type             kind,
   output logic [ByteWidth-1:0] data_out
);

   state_type cur;

   always_comb begin
      cur       = restart ? STATE_RESET : state_cur;
      state_nxt = cur;
      kind      = KIND_HDR;
      data_out  = '0;

      case (cur.phase)
         PH_MAGIC1: begin
            if (in_byte == MAGIC1_BYTE) begin
               state_nxt.phase = PH_MAGIC2;
            end else begin
               state_nxt.phase = PH_BADMAGIC;
               kind            = KIND_BADMAGIC;
            end
         end
         PH_MAGIC2: begin
            if (in_byte == MAGIC2_BYTE) begin
               state_nxt.phase = PH_METHOD;
            end else begin
               state_nxt.phase = PH_BADMAGIC;
               kind            = KIND_BADMAGIC;
            end
         end
         PH_METHOD: begin
            if (in_byte == METHOD_DEFLATE) begin
               state_nxt.phase = PH_FLAGS;
            end else begin
               state_nxt.phase = PH_BADMETH;
               kind            = KIND_BADMETH;
            end
         end
         PH_FLAGS: begin
            state_nxt.flags      = in_byte;
            state_nxt.mtime      = '0;
            state_nxt.byte_count = '0;
            state_nxt.phase      = PH_MTIME;
         end
         PH_MTIME: begin
            // merge this byte into its little-endian lane
            case (cur.byte_count)
               2'd0:    state_nxt.mtime[7:0]   = cur.mtime[7:0]   | in_byte;
               2'd1:    state_nxt.mtime[15:8]  = cur.mtime[15:8]  | in_byte;
               2'd2:    state_nxt.mtime[23:16] = cur.mtime[23:16] | in_byte;
               default: state_nxt.mtime[31:24] = cur.mtime[31:24] | in_byte;
            endcase
            state_nxt.byte_count = cur.byte_count + 2'd1;
            if (cur.byte_count == 2'd3) state_nxt.phase = PH_XFL;
         end
         PH_XFL: begin
            state_nxt.phase = PH_OS;
         end
         PH_OS: begin
            state_nxt.phase      = section_after(PH_OS, cur.flags);
            state_nxt.byte_count = '0;
            if (state_nxt.phase == PH_PAYLOAD) kind = KIND_DONE;
         end
         PH_XLEN: begin
            if (cur.byte_count == 2'd0) begin
               state_nxt.extra_left = {{(XlenWidth-ByteWidth){1'b0}}, in_byte};
               state_nxt.byte_count = 2'd1;
            end else begin
               state_nxt.extra_left = {in_byte, cur.extra_left[ByteWidth-1:0]};
               state_nxt.byte_count = '0;
               if (state_nxt.extra_left == '0) begin
                  state_nxt.phase = section_after(PH_EXTRA, cur.flags);
                  if (state_nxt.phase == PH_PAYLOAD) kind = KIND_DONE;
               end else begin
                  state_nxt.phase = PH_EXTRA;
               end
            end
         end
         PH_EXTRA: begin
            state_nxt.extra_left = cur.extra_left - 16'd1;
            if (state_nxt.extra_left == '0) begin
               state_nxt.phase      = section_after(PH_EXTRA, cur.flags);
               state_nxt.byte_count = '0;
               if (state_nxt.phase == PH_PAYLOAD) kind = KIND_DONE;
            end
         end
         PH_NAME: begin
            if (in_byte == '0) begin
               state_nxt.phase      = section_after(PH_NAME, cur.flags);
               state_nxt.byte_count = '0;
               if (state_nxt.phase == PH_PAYLOAD) kind = KIND_DONE;
            end else begin
               kind     = KIND_NAME;
               data_out = in_byte;
            end
         end
         PH_COMMENT: begin
            if (in_byte == '0) begin
               state_nxt.phase      = section_after(PH_COMMENT, cur.flags);
               state_nxt.byte_count = '0;
               if (state_nxt.phase == PH_PAYLOAD) kind = KIND_DONE;
            end
         end
         PH_HCRC: begin
            if (cur.byte_count == 2'd0) begin
               state_nxt.byte_count = 2'd1;
            end else begin
               state_nxt.phase      = section_after(PH_HCRC, cur.flags);
               state_nxt.byte_count = '0;
               if (state_nxt.phase == PH_PAYLOAD) kind = KIND_DONE;
            end
         end
         PH_PAYLOAD: begin
            kind     = KIND_PAYLOAD;
            data_out = in_byte;
         end
         PH_BADMAGIC: begin
            kind = KIND_BADMAGIC;
         end
         default: begin
            state_nxt.phase = PH_BADMETH;
            kind            = KIND_BADMETH;
         end
      endcase
   end

endmodule

// File: tb/sv/tb_gzip_member_header_parser.sv
`timescale 1ns / 1ps

module tb_gzip_member_header_parser;
   import gmhp_pkg::*;

   localparam int HOLD_OFF_CYCLES = 400;
   localparam int DRAIN_LIMIT     = 100000;

   typedef struct packed {
      kind_type              kind;
      logic [ByteWidth-1:0]  data;
      logic [ByteWidth-1:0]  flags;
      logic [TimeWidth-1:0]  mtime;
   } parse_result_type;

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     req_tvalid = 1'b0;
   logic                     req_tready;
   logic [ByteWidth-1:0]     req_tdata = '0;   // [7:0] in_byte
   logic [0:0]               req_tuser = '0;   // [0] restart
   logic                     rsp_tvalid;
   logic                     rsp_tready = 1'b0;
   logic [RspDataWidth-1:0]  rsp_tdata;        // [7:0] data_out, [15:8] flags_out,
                                               // [47:16] mtime_out
   logic [KindWidth-1:0]     rsp_tuser;        // [2:0] kind

   // parser state as the predictor sees it
   phase_type              hdr_phase = PH_MAGIC1;
   logic [ByteWidth-1:0]   hdr_flags = '0;
   logic [TimeWidth-1:0]   hdr_mtime = '0;
   logic [1:0]             hdr_count = '0;
   logic [XlenWidth-1:0]   hdr_extra_left = '0;

   parse_result_type  expected_results[$];
   logic [7:0]        member_q[$];
   parse_result_type  want;
   int                fail_count = 0;
   int                words_sent = 0;
   bit                idle_en = 1'b1;
   bit                hold_off_req = 1'b0;

   gzip_member_header_parser DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   initial begin
      #20_000_000;
      $display("FAILURE");
      $finish;
   end

   // Append one byte to the member being built.
   function automatic void add_byte(input logic [7:0] b);
      member_q.insert(member_q.size(), b);
   endfunction

   // Move to the next enabled optional section; header complete if none is left.
   function automatic kind_type close_section(input phase_type done);
      hdr_count = '0;
      if (done < PH_XLEN && (hdr_flags & FL_EXTRA) != '0) hdr_phase = PH_XLEN;
      else if (done < PH_NAME && (hdr_flags & FL_NAME) != '0) hdr_phase = PH_NAME;
      else if (done < PH_COMMENT && (hdr_flags & FL_COMMENT) != '0) hdr_phase = PH_COMMENT;
      else if (done < PH_HCRC && (hdr_flags & FL_HCRC) != '0) hdr_phase = PH_HCRC;
      else hdr_phase = PH_PAYLOAD;
      return (hdr_phase == PH_PAYLOAD) ? KIND_DONE : KIND_HDR;
   endfunction

   function automatic parse_result_type parse_byte(input logic [7:0] b, input logic restart);
      parse_result_type r;
      r.kind = KIND_HDR;
      r.data = '0;
      if (restart) begin
         hdr_phase = PH_MAGIC1;
         hdr_flags = '0;
         hdr_mtime = '0;
         hdr_count = '0;
         hdr_extra_left = '0;
      end
      case (hdr_phase)
         PH_MAGIC1: begin
            if (b == MAGIC1_BYTE) hdr_phase = PH_MAGIC2;
            else begin
               hdr_phase = PH_BADMAGIC;
               r.kind = KIND_BADMAGIC;
            end
         end
         PH_MAGIC2: begin
            if (b == MAGIC2_BYTE) hdr_phase = PH_METHOD;
            else begin
               hdr_phase = PH_BADMAGIC;
               r.kind = KIND_BADMAGIC;
            end
         end
         PH_METHOD: begin
            if (b == METHOD_DEFLATE) hdr_phase = PH_FLAGS;
            else begin
               hdr_phase = PH_BADMETH;
               r.kind = KIND_BADMETH;
            end
         end
         PH_FLAGS: begin
            hdr_flags = b;
            hdr_mtime = '0;
            hdr_count = '0;
            hdr_phase = PH_MTIME;
         end
         PH_MTIME: begin
            hdr_mtime = hdr_mtime | (32'(b) << (8 * hdr_count));
            if (hdr_count == 2'd3) hdr_phase = PH_XFL;
            hdr_count = hdr_count + 2'd1;
         end
         PH_XFL: hdr_phase = PH_OS;
         PH_OS: r.kind = close_section(PH_OS);
         PH_XLEN: begin
            if (hdr_count == 2'd0) begin
               hdr_extra_left = {8'd0, b};
               hdr_count = 2'd1;
            end else begin
               hdr_extra_left = {b, hdr_extra_left[7:0]};
               hdr_count = 2'd0;
               if (hdr_extra_left == '0) r.kind = close_section(PH_EXTRA);
               else hdr_phase = PH_EXTRA;
            end
         end
         PH_EXTRA: begin
            hdr_extra_left = hdr_extra_left - 16'd1;
            if (hdr_extra_left == '0) r.kind = close_section(PH_EXTRA);
         end
         PH_NAME: begin
            if (b == 8'd0) r.kind = close_section(PH_NAME);
            else begin
               r.kind = KIND_NAME;
               r.data = b;
            end
         end
         PH_COMMENT: begin
            if (b == 8'd0) r.kind = close_section(PH_COMMENT);
         end
         PH_HCRC: begin
            if (hdr_count == 2'd0) hdr_count = 2'd1;
            else r.kind = close_section(PH_HCRC);
         end
         PH_PAYLOAD: begin
            r.kind = KIND_PAYLOAD;
            r.data = b;
         end
         PH_BADMAGIC: r.kind = KIND_BADMAGIC;
         default: begin
            hdr_phase = PH_BADMETH;
            r.kind = KIND_BADMETH;
         end
      endcase
      r.flags = hdr_flags;
      r.mtime = hdr_mtime;
      return r;
   endfunction

   // Mostly short gaps, a few long ones.
   function automatic int pick_gap();
      int r;
      if (!idle_en) return 0;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 90) return $urandom_range(1, 3);
      if (r < 98) return $urandom_range(4, 10);
      return $urandom_range(20, 60);
   endfunction

   function automatic logic [7:0] pick_byte();
      int r;
      r = $urandom_range(0, 7);
      if (r == 0) return 8'h00;
      if (r == 1) return 8'hff;
      return 8'($urandom_range(0, 255));
   endfunction

   task automatic send_word(input logic [7:0] b, input logic restart);
      int gap;
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      req_tuser  <= restart;
      do @(posedge clock); while (!req_tready);
      expected_results.insert(expected_results.size(), parse_byte(b, restart));
      words_sent++;
      gap = pick_gap();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic send_queue(input bit restart_first, input int count);
      for (int i = 0; i < count; i++) send_word(member_q[i], restart_first && (i == 0));
   endtask

   // Build one member, optionally corrupt one byte or cut it short, and send it.
   task automatic send_member(input logic [7:0] flg, input int xlen, input int name_len,
                              input int cmt_len, input int pay_len,
                              input int corrupt_at, input int keep);
      int count;
      member_q = {MAGIC1_BYTE, MAGIC2_BYTE, METHOD_DEFLATE, flg};
      repeat (4) add_byte(pick_byte());
      add_byte(pick_byte());
      add_byte(pick_byte());
      if ((flg & FL_EXTRA) != '0) begin
         add_byte(xlen[7:0]);
         add_byte(xlen[15:8]);
         repeat (xlen) add_byte(pick_byte());
      end
      if ((flg & FL_NAME) != '0) begin
         repeat (name_len) add_byte(8'($urandom_range(1, 255)));
         add_byte(8'h00);
      end
      if ((flg & FL_COMMENT) != '0) begin
         repeat (cmt_len) add_byte(8'($urandom_range(1, 255)));
         add_byte(8'h00);
      end
      if ((flg & FL_HCRC) != '0) repeat (2) add_byte(pick_byte());
      repeat (pay_len) add_byte(pick_byte());
      if (corrupt_at >= 0) member_q[corrupt_at] ^= 8'($urandom_range(1, 255));
      count = member_q.size();
      if (keep >= 0 && keep < count) count = keep;
      send_queue(1'b1, count);
   endtask

   function automatic int pick_xlen();
      int r;
      r = $urandom_range(0, 99);
      if (r < 70) return $urandom_range(0, 3);
      if (r < 95) return $urandom_range(4, 20);
      return $urandom_range(100, 300);
   endfunction

   // Error paths first: bad first magic (sticky), bad second magic, bad method (sticky).
   // Then one header with reserved flag bits, full mtime and an empty extra field.
   task automatic test_directed();
      member_q = {8'h00, 8'hff};
      send_queue(1'b0, member_q.size());
      member_q = {MAGIC1_BYTE, 8'h00};
      send_queue(1'b1, member_q.size());
      member_q = {MAGIC1_BYTE, MAGIC2_BYTE, 8'h09, METHOD_DEFLATE};
      send_queue(1'b1, member_q.size());
      member_q = {MAGIC1_BYTE, MAGIC2_BYTE, METHOD_DEFLATE, 8'he0 | FL_EXTRA,
                  8'hff, 8'hff, 8'hff, 8'hff, 8'h00, 8'hff, 8'h00, 8'h00, 8'h00, 8'hff};
      send_queue(1'b1, member_q.size());
   endtask

   task automatic test_random_members();
      int stop_at;
      stop_at = words_sent + 250;
      while (words_sent < stop_at) begin
         idle_en = ($urandom_range(0, 3) != 0);
         send_member(8'($urandom_range(0, 255)), pick_xlen(), $urandom_range(0, 6),
                     $urandom_range(0, 4), $urandom_range(0, 8), -1, -1);
      end
      idle_en = 1'b1;
   endtask

   task automatic test_broken_members();
      repeat (12) begin
         case ($urandom_range(0, 1))
            0: send_member(8'($urandom_range(0, 255)), pick_xlen(), 2, 2, 3,
                           $urandom_range(0, 2), -1);
            default: send_member(8'($urandom_range(0, 255)), pick_xlen(), 3, 2, 3,
                                 -1, $urandom_range(1, 14));
         endcase
      end
   endtask

   task automatic test_noise();
      repeat (120) send_word(pick_byte(), $urandom_range(0, 7) == 0);
   endtask

   // Receiver holds off while the sender keeps offering back to back words.
   task automatic test_backpressure();
      idle_en = 1'b0;
      hold_off_req = 1'b1;
      send_member(FL_NAME, 0, 4, 0, 40, -1, -1);
      idle_en = 1'b1;
   endtask

   // Extra field longer than 255 bytes: the countdown borrows from the high length byte.
   task automatic test_long_extra();
      idle_en = 1'b0;
      send_member(FL_EXTRA | FL_HCRC, 16'h0101, 0, 0, 2, -1, -1);
      idle_en = 1'b1;
   endtask

   initial begin
      int stall;
      stall = 0;
      forever begin
         @(posedge clock);
         if (hold_off_req) begin
            hold_off_req = 1'b0;
            rsp_tready <= 1'b0;
            repeat (HOLD_OFF_CYCLES) @(posedge clock);
            rsp_tready <= 1'b1;
         end else if (stall > 0) begin
            stall--;
            rsp_tready <= 1'b0;
         end else begin
            stall = pick_gap();
            if (stall > 0) begin
               stall--;
               rsp_tready <= 1'b0;
            end else begin
               rsp_tready <= 1'b1;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_results.size() == 0) begin
            fail_count++;
            if (fail_count <= 10)
               $display("unexpected result: kind %0d tdata %h", rsp_tuser, rsp_tdata);
         end else begin
            want = expected_results.pop_front();
            if (rsp_tuser !== want.kind || rsp_tdata[7:0] !== want.data ||
                rsp_tdata[15:8] !== want.flags || rsp_tdata[47:16] !== want.mtime) begin
               fail_count++;
               if (fail_count <= 10)
                  $display("mismatch: kind %0d/%0d data %h/%h flags %h/%h mtime %h/%h",
                           want.kind, rsp_tuser, want.data, rsp_tdata[7:0],
                           want.flags, rsp_tdata[15:8], want.mtime, rsp_tdata[47:16]);
            end
         end
      end
   end

   initial begin
      int waited;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      test_directed();
      test_random_members();
      test_broken_members();
      test_noise();
      test_backpressure();
      test_long_extra();
      req_tvalid <= 1'b0;
      idle_en = 1'b0;
      waited = 0;
      while (expected_results.size() != 0 && waited < DRAIN_LIMIT) begin
         @(posedge clock);
         waited++;
      end
      fail_count += expected_results.size();
      repeat (8) @(posedge clock);
      if (fail_count == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule

// File: gzip_member_header_parser.f
rtl/core/gmhp_pkg.sv
rtl/core/gmhp_step.sv
rtl/core/gzip_member_header_parser.sv
tb/sv/tb_gzip_member_header_parser.sv
